### src/gsds_pkg.sv
// Package for the glyph signed distance sampler: sizes, field widths and the
// sequencer state type. Used by the sampler module and the bench.
package gsds_pkg;

    localparam int MAX_GLYPH_WIDTH  = 64;
    localparam int MAX_GLYPH_HEIGHT = 64;
    localparam int MAX_SPREAD       = 32;
    localparam int STORE_DEPTH      = MAX_GLYPH_WIDTH * MAX_GLYPH_HEIGHT;
    localparam int ADDR_W           = $clog2(STORE_DEPTH);
    localparam int XW               = $clog2(MAX_GLYPH_WIDTH);
    localparam int YW               = $clog2(MAX_GLYPH_HEIGHT);
    localparam int SPW              = $clog2(MAX_SPREAD) + 1;
    // Window offsets run from -spread to spread-1.
    localparam int OFW              = SPW + 1;
    // Squared distance, capped at spread squared.
    localparam int D2W              = 2 * SPW;
    // Scaled center: |coord| <= 128 times a 16-bit ratio, shifted by 8, plus sign.
    localparam int CW               = 18;
    // Distance root in Q6.8 and its digit count.
    localparam int SQW              = D2W + 16;
    localparam int RTW              = SQW / 2;
    localparam int NUMW             = SPW + 10;
    localparam int DIVW             = NUMW;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_GLYPH_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GLYPH_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SPREAD       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE_X      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE_Y      = 3'd4;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CENTER,
        ST_SCAN,
        ST_DRAIN,
        ST_SQRT,
        ST_NUM,
        ST_DIV,
        ST_DONE
    } gsds_state_t;

endpackage

### src/gsds_if.sv
// Valid/ready channel interfaces for the sampler's item input and result output.
// Does not import gsds_pkg; the field widths are written out directly.
interface gsds_in_if;
    logic        valid;
    logic        ready;
    logic        cmd;
    logic [11:0] pixel_index;
    logic [7:0]  pixel_value;
    logic signed [7:0] out_x;
    logic signed [7:0] out_y;

    modport source (output valid, cmd, pixel_index, pixel_value, out_x, out_y, input ready);
    modport sink (input valid, cmd, pixel_index, pixel_value, out_x, out_y, output ready);
endinterface

interface gsds_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] distance_value;
    logic       inside_res;

    modport source (output valid, distance_value, inside_res, input ready);
    modport sink (input valid, distance_value, inside_res, output ready);
endinterface

### src/gsds_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read data.
// Standalone; no package dependency.
module gsds_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### src/glyph_signed_distance_sampler.sv
// Glyph signed distance sampler. Load beats write one bitmap pixel each and
// give no result. A query beat reads the center pixel, then the window scan
// reads one pixel per cycle from the single read port of the bitmap RAM, and
// after a drain step for the last compare a digit-serial square root, a
// numerator step and a bit-serial divide finish the distance value.
// One query is worked on at a time; the next beat is taken once the sequencer
// is idle, and a finished result waits in the output register until taken.
module glyph_signed_distance_sampler
    import gsds_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    gsds_in_if.sink               in_ch,
    gsds_out_if.source            out_ch
);

    gsds_state_t state_reg, state_next;

    logic [6:0]  glyph_width_reg, glyph_height_reg;
    logic [5:0]  spread_reg;
    logic [15:0] scale_x_reg, scale_y_reg;

    logic signed [CW-1:0]  px_reg, py_reg;
    logic signed [OFW-1:0] dx_reg, dy_reg;
    logic                  pv_reg, pcenter_reg, pinb_reg;
    logic [D2W-1:0]        pd2_reg;
    logic                  inside_reg;
    logic [D2W-1:0]        best_reg;
    logic [SQW-1:0]        sqv_reg;
    logic [RTW+2:0]        sqrem_reg;
    logic [RTW-1:0]        root_reg;
    logic [4:0]            cnt_reg;
    logic [DIVW-1:0]       dvd_reg;
    logic [SPW:0]          drem_reg;
    logic [DIVW-1:0]       quo_reg;
    logic                  out_valid_reg;
    logic [7:0]            out_dist_reg;
    logic                  out_inside_reg;

    logic [SPW-1:0]  s_eff;
    logic [6:0]      w_eff, h_eff;
    logic [SPW:0]    k_den;
    logic            accept, is_load, is_query;
    logic            last_pos;
    logic signed [OFW-1:0] ox, oy;
    logic signed [CW-1:0]  cx, cy;
    logic            inb;
    logic [ADDR_W-1:0] raddr;
    logic            rdata;
    logic [D2W-1:0]  d2;
    logic            pix;
    logic            best_hit;
    logic [D2W-1:0]  best_fwd;
    logic            in_ready;
    logic [RTW+2:0]  sq_shift, sq_trial;
    logic [SPW:0]    dv_shift;
    logic [NUMW-1:0] num;
    logic [NUMW+7:0] prod;

    // Effective configuration after clamping.
    always_comb
    begin
        if (spread_reg == '0)
        begin
            s_eff = SPW'(1);
        end
        else if ({2'b0, spread_reg} > 8'(MAX_SPREAD))
        begin
            s_eff = SPW'(MAX_SPREAD);
        end
        else
        begin
            s_eff = SPW'(spread_reg);
        end
        w_eff = ({1'b0, glyph_width_reg} > 8'(MAX_GLYPH_WIDTH))
                ? 7'(MAX_GLYPH_WIDTH) : glyph_width_reg;
        h_eff = ({1'b0, glyph_height_reg} > 8'(MAX_GLYPH_HEIGHT))
                ? 7'(MAX_GLYPH_HEIGHT) : glyph_height_reg;
        k_den = {s_eff, 1'b0} - (SPW+1)'(1);
    end

    assign accept   = in_ch.valid && in_ready;
    assign is_load  = accept && (in_ch.cmd == CMD_LOAD);
    assign is_query = accept && (in_ch.cmd == CMD_QUERY);
    assign last_pos = (dx_reg == OFW'(s_eff) - OFW'(1)) && (dy_reg == OFW'(s_eff) - OFW'(1));

    // Scaled center, truncated toward zero.
    always_comb
    begin
        logic [7:0]  mx, my;
        logic [23:0] tx, ty;
        mx = in_ch.out_x[7] ? 8'(-in_ch.out_x) : 8'(in_ch.out_x);
        my = in_ch.out_y[7] ? 8'(-in_ch.out_y) : 8'(in_ch.out_y);
        tx = mx * scale_x_reg;
        ty = my * scale_y_reg;
        cx = in_ch.out_x[7] ? -CW'(signed'({1'b0, tx[23:8]})) : CW'(signed'({1'b0, tx[23:8]}));
        cy = in_ch.out_y[7] ? -CW'(signed'({1'b0, ty[23:8]})) : CW'(signed'({1'b0, ty[23:8]}));
    end

    // Read address for the pixel being issued this cycle.
    always_comb
    begin
        logic signed [CW-1:0] x, y;
        logic [ADDR_W+6:0]   a;
        ox = (state_reg == ST_CENTER) ? '0 : dx_reg;
        oy = (state_reg == ST_CENTER) ? '0 : dy_reg;
        x  = px_reg + CW'(ox);
        y  = py_reg + CW'(oy);
        inb = (x >= 0) && (y >= 0) && (x < CW'(signed'({1'b0, w_eff})))
              && (y < CW'(signed'({1'b0, h_eff})));
        a = (ADDR_W+7)'(y[YW-1:0]) * (ADDR_W+7)'(w_eff) + (ADDR_W+7)'(x[XW-1:0]);
        raddr = inb ? a[ADDR_W-1:0] : '0;
        d2 = D2W'(D2W'(ox) * D2W'(ox) + D2W'(oy) * D2W'(oy));
    end

    gsds_ram #(
        .WIDTH(1),
        .DEPTH(STORE_DEPTH)
    ) u_store (
        .clk  (clk),
        .we   (is_load),
        .waddr(in_ch.pixel_index[ADDR_W-1:0]),
        .wdata(in_ch.pixel_value != 8'd0),
        .raddr(raddr),
        .rdata(rdata)
    );

    assign pix = pinb_reg && rdata;

    // The last window pixel is compared in the drain cycle, so its minimum is passed on.
    assign best_hit = pv_reg && !pcenter_reg && (pix != inside_reg) && (pd2_reg < best_reg);
    assign best_fwd = best_hit ? pd2_reg : best_reg;

    // Square root digit step and divide step.
    always_comb
    begin
        sq_shift = {sqrem_reg[RTW:0], sqv_reg[SQW-1 -: 2]};
        sq_trial = (RTW+3)'({root_reg, 2'b01});
        dv_shift = {drem_reg[SPW-1:0], dvd_reg[DIVW-1]};
        if (inside_reg)
        begin
            num = NUMW'(k_den) * NUMW'(128) + NUMW'(root_reg) - NUMW'(128);
        end
        else
        begin
            num = NUMW'(s_eff) * NUMW'(256) - NUMW'(root_reg);
        end
        prod = (NUMW+8)'({num, 8'd0}) - (NUMW+8)'(num);
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:   if (is_query) state_next = ST_CENTER;
            ST_CENTER: state_next = ST_SCAN;
            ST_SCAN:   if (last_pos) state_next = ST_DRAIN;
            ST_DRAIN:  state_next = ST_SQRT;
            ST_SQRT:   if (cnt_reg == 5'(RTW - 1)) state_next = ST_NUM;
            ST_NUM:    state_next = ST_DIV;
            ST_DIV:    if (cnt_reg == 5'(DIVW - 1)) state_next = ST_DONE;
            ST_DONE:   if (!out_valid_reg || out_ch.ready) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // Handshake outputs.
    always_comb
    begin
        case (state_reg)
            ST_IDLE: in_ready = 1'b1;
            default: in_ready = 1'b0;
        endcase
    end

    assign in_ch.ready           = in_ready;
    assign out_ch.valid          = out_valid_reg;
    assign out_ch.distance_value = out_dist_reg;
    assign out_ch.inside_res     = out_inside_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            glyph_width_reg  <= 7'd64;
            glyph_height_reg <= 7'd64;
            spread_reg       <= 6'd16;
            scale_x_reg      <= 16'd256;
            scale_y_reg      <= 16'd256;
            out_valid_reg    <= 1'b0;
            pv_reg           <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_GLYPH_WIDTH:  glyph_width_reg  <= cfg_data[6:0];
                    REG_GLYPH_HEIGHT: glyph_height_reg <= cfg_data[6:0];
                    REG_SPREAD:       spread_reg       <= cfg_data[5:0];
                    REG_SCALE_X:      scale_x_reg      <= cfg_data;
                    REG_SCALE_Y:      scale_y_reg      <= cfg_data;
                    default:          ;
                endcase
            end
            pv_reg <= (state_reg == ST_CENTER) || (state_reg == ST_SCAN);
            if (out_valid_reg && out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (state_reg == ST_DONE && state_next == ST_IDLE)
            begin
                out_valid_reg <= 1'b1;
            end
        end
    end

    // Datapath.
    always_ff @(posedge clk)
    begin
        if (is_query)
        begin
            px_reg <= cx;
            py_reg <= cy;
            dx_reg <= -OFW'(s_eff);
            dy_reg <= -OFW'(s_eff);
            best_reg <= D2W'(s_eff) * D2W'(s_eff);
        end
        pcenter_reg <= (state_reg == ST_CENTER);
        pinb_reg    <= inb;
        pd2_reg     <= d2;
        if (state_reg == ST_SCAN)
        begin
            if (dx_reg == OFW'(s_eff) - OFW'(1))
            begin
                dx_reg <= -OFW'(s_eff);
                dy_reg <= dy_reg + OFW'(1);
            end
            else
            begin
                dx_reg <= dx_reg + OFW'(1);
            end
        end
        // Compare stage, in the cycle after the read it belongs to.
        if (pv_reg)
        begin
            if (pcenter_reg)
            begin
                inside_reg <= pix;
            end
            else if (best_hit)
            begin
                best_reg <= pd2_reg;
            end
        end
        if (state_reg == ST_DRAIN)
        begin
            sqv_reg   <= {best_fwd, 16'd0};
            sqrem_reg <= '0;
            root_reg  <= '0;
            cnt_reg   <= '0;
        end
        if (state_reg == ST_SQRT)
        begin
            sqv_reg <= {sqv_reg[SQW-3:0], 2'b00};
            cnt_reg <= cnt_reg + 5'd1;
            if (sq_shift >= sq_trial)
            begin
                sqrem_reg <= sq_shift - sq_trial;
                root_reg  <= {root_reg[RTW-2:0], 1'b1};
            end
            else
            begin
                sqrem_reg <= sq_shift;
                root_reg  <= {root_reg[RTW-2:0], 1'b0};
            end
        end
        if (state_reg == ST_NUM)
        begin
            // 255 * num / (256 * k) is (255 * num >> 8) / k.
            dvd_reg  <= prod[NUMW+7:8];
            drem_reg <= '0;
            quo_reg  <= '0;
            cnt_reg  <= '0;
        end
        if (state_reg == ST_DIV)
        begin
            dvd_reg <= {dvd_reg[DIVW-2:0], 1'b0};
            cnt_reg <= cnt_reg + 5'd1;
            if (dv_shift >= k_den)
            begin
                drem_reg <= dv_shift - k_den;
                quo_reg  <= {quo_reg[DIVW-2:0], 1'b1};
            end
            else
            begin
                drem_reg <= dv_shift;
                quo_reg  <= {quo_reg[DIVW-2:0], 1'b0};
            end
        end
        if (state_reg == ST_DONE && state_next == ST_IDLE)
        begin
            out_dist_reg   <= quo_reg[7:0];
            out_inside_reg <= inside_reg;
        end
    end

endmodule

### bench/glyph_signed_distance_sampler_test.sv
// Self-checking bench for the glyph signed distance sampler: loads a glyph,
// queries distances and checks each result against a behavioral predictor.
// Depends on gsds_pkg and the channel interfaces in gsds_if.
`timescale 1ns / 100ps

module glyph_signed_distance_sampler_test;
    import gsds_pkg::*;

    localparam int HALF_PERIOD = 4;
    localparam int STALL_LIMIT = 200000;
    localparam int FILL_DEPTH  = 64;

    typedef struct {
        logic [7:0] distance_value;
        logic       inside_res;
    } sdf_result_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_write;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    gsds_in_if  in_ch ();
    gsds_out_if out_ch ();

    glyph_signed_distance_sampler uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    // Predictor state.
    bit          glyph_bits [0:STORE_DEPTH-1];
    int unsigned cfg_width, cfg_height, cfg_spread, cfg_scale_x, cfg_scale_y;
    sdf_result_t pending_results [$];

    int send_idle_pct;
    int recv_stall_pct;
    int hold_off_cycles;
    int error_count;
    int load_count;
    int query_count;
    int result_count;
    int stall_cycles;

    always
    begin
        #HALF_PERIOD clk = 1'b1;
        #HALF_PERIOD clk = 1'b0;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("ERROR %0t: %s got %0d expected %0d", $time, what, got, want);
        error_count++;
    endtask

    function automatic int scale_point(input int coord, input int unsigned ratio);
        int mag;
        int r;
        mag = coord < 0 ? -coord : coord;
        r = int'((mag * ratio) >> 8);
        return coord < 0 ? -r : r;
    endfunction

    function automatic bit pixel_at(input int x, input int y, input int w, input int h);
        if (x < 0 || y < 0 || x >= w || y >= h)
            return 1'b0;
        return glyph_bits[y * w + x];
    endfunction

    function automatic int unsigned root_floor(input longint unsigned v);
        longint unsigned r;
        longint unsigned t;
        r = 0;
        for (int b = 15; b >= 0; b--)
        begin
            t = r | (longint'(1) << b);
            if (t * t <= v)
                r = t;
        end
        return int'(r);
    endfunction

    function automatic sdf_result_t predict_distance(input logic signed [7:0] ox,
                                                     input logic signed [7:0] oy);
        sdf_result_t res;
        int w, h, s, px, py;
        bit center;
        int unsigned best, d2, root, num, den;
        w = cfg_width > MAX_GLYPH_WIDTH ? MAX_GLYPH_WIDTH : cfg_width;
        h = cfg_height > MAX_GLYPH_HEIGHT ? MAX_GLYPH_HEIGHT : cfg_height;
        s = cfg_spread;
        if (s < 1)
            s = 1;
        if (s > MAX_SPREAD)
            s = MAX_SPREAD;
        px = scale_point(int'(ox), cfg_scale_x);
        py = scale_point(int'(oy), cfg_scale_y);
        center = pixel_at(px, py, w, h);
        best = s * s;
        for (int y = py - s; y < py + s; y++)
            for (int x = px - s; x < px + s; x++)
            begin
                d2 = (x - px) * (x - px) + (y - py) * (y - py);
                if (pixel_at(x, y, w, h) != center && d2 < best)
                    best = d2;
            end
        root = root_floor(longint'(best) << 16);
        den = 256 * (2 * s - 1);
        if (center)
            num = 128 * (2 * s - 1) + root - 128;
        else
            num = 256 * s - root;
        res.distance_value = 8'((255 * num) / den);
        res.inside_res = center;
        return res;
    endfunction

    // Sends one beat; on return the beat has just been accepted at this edge.
    task automatic send_beat(input logic cmd, input logic [11:0] index,
                             input logic [7:0] value, input logic [7:0] ox,
                             input logic [7:0] oy);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct && gap < 12)
            gap++;
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.cmd         <= cmd;
        in_ch.pixel_index <= index;
        in_ch.pixel_value <= value;
        in_ch.out_x       <= ox;
        in_ch.out_y       <= oy;
        forever
        begin
            @(negedge clk);
            if (in_ch.ready)
                break;
        end
        @(posedge clk);
        if (cmd == CMD_LOAD)
        begin
            glyph_bits[index] = (value != 8'd0);
            load_count++;
        end
        else
        begin
            pending_results.push_back(predict_distance(ox, oy));
            query_count++;
        end
    endtask

    task automatic send_load(input int index, input logic [7:0] value);
        send_beat(CMD_LOAD, 12'(index), value, 8'($urandom), 8'($urandom));
    endtask

    task automatic send_query(input int ox, input int oy);
        send_beat(CMD_QUERY, 12'($urandom), 8'($urandom), 8'(ox), 8'(oy));
    endtask

    // Lowers valid and waits out every pending result plus the load latency.
    task automatic drain_block();
        in_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // Leaves the write enable high; the caller lowers it after the last write.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_DATA_W'(value);
        @(posedge clk);
        case (idx)
            REG_GLYPH_WIDTH:  cfg_width = value & 'h7F;
            REG_GLYPH_HEIGHT: cfg_height = value & 'h7F;
            REG_SPREAD:       cfg_spread = value & 'h3F;
            REG_SCALE_X:      cfg_scale_x = value & 'hFFFF;
            REG_SCALE_Y:      cfg_scale_y = value & 'hFFFF;
            default: ;
        endcase
    endtask

    task automatic set_config(input int w, input int h, input int s, input int sx,
                              input int sy);
        drain_block();
        write_reg(REG_GLYPH_WIDTH, w);
        write_reg(REG_GLYPH_HEIGHT, h);
        write_reg(REG_SPREAD, s);
        write_reg(REG_SCALE_X, sx);
        write_reg(REG_SCALE_Y, sy);
        cfg_write <= 1'b0;
    endtask

    // The first 64 entries are written first, and every geometry used keeps
    // width times height within them, so no query reads an unwritten pixel.
    task automatic test_fill_and_defaults();
        int dx, dy;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        for (int i = 0; i < FILL_DEPTH; i++)
        begin
            dx = (i % 8) - 3;
            dy = (i / 8) - 3;
            if (dx * dx + dy * dy < 8 && $urandom_range(15) != 0)
                send_load(i, 8'($urandom_range(1, 255)));
            else
                send_load(i, ($urandom_range(7) == 0) ? 8'($urandom_range(1, 255)) : 8'd0);
        end
        send_load(0, 8'hFF);
        send_load(FILL_DEPTH - 1, 8'h00);
        // Default width, spread and ratios over a single row.
        drain_block();
        write_reg(REG_GLYPH_HEIGHT, 1);
        cfg_write <= 1'b0;
        send_query(0, 0);
        send_query(30, 0);
        send_query(-64, -64);
        send_query(127, 127);
        send_query(-1, 40);
        send_query(63, 0);
    endtask

    task automatic test_config_extremes();
        set_config(0, 64, 4, 256, 256);
        send_query(30, 28);
        set_config(127, 1, 0, 256, 256);
        send_query(30, 28);
        send_query(40, 0);
        set_config(64, 0, 1, 256, 256);
        send_query(10, 10);
        set_config(8, 8, 63, 256, 256);
        send_query(3, 3);
        send_query(-20, 5);
        set_config(8, 8, 3, 0, 65535);
        send_query(-128, 0);
        send_query(127, -1);
        set_config(1, 1, 2, 65535, 0);
        send_query(0, 5);
        send_query(-128, 127);
        set_config(16, 4, 32, 128, 384);
        send_query(20, 1);
    endtask

    // The receiver holds off while queries keep coming, so the input must stall.
    task automatic test_backpressure();
        set_config(8, 8, 2, 256, 256);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_off_cycles = 400;
        for (int i = 0; i < 8; i++)
            send_query($urandom_range(0, 10), $urandom_range(0, 10));
        drain_block();
        for (int i = 0; i < 4; i++)
            send_query($urandom_range(0, 10), $urandom_range(0, 10));
    endtask

    task automatic test_random_phase(input int idle_pct, input int stall_pct, input int beats);
        int s, wv, hv;
        s = ($urandom_range(5) == 0) ? $urandom_range(1, 16) : $urandom_range(0, 5);
        wv = $urandom_range(1, 64);
        hv = $urandom_range(1, 64 / wv);
        if ($urandom_range(7) == 0)
        begin
            wv = $urandom_range(64, 127);
            hv = $urandom_range(0, 1);
        end
        else if ($urandom_range(9) == 0)
        begin
            wv = 0;
            hv = $urandom_range(0, 127);
        end
        set_config(wv, hv, s, $urandom_range(64, 640), $urandom_range(64, 640));
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        for (int i = 0; i < beats; i++)
        begin
            if ($urandom_range(99) < 40)
            begin
                if ($urandom_range(3) == 0)
                    send_query($urandom_range(0, 255) - 128, $urandom_range(0, 255) - 128);
                else
                    send_query($urandom_range(0, 16), $urandom_range(0, 16));
            end
            else
                send_load($urandom_range(0, FILL_DEPTH - 1), 8'($urandom));
        end
    endtask

    always @(posedge clk)
    begin
        if (hold_off_cycles > 0)
        begin
            out_ch.ready <= 1'b0;
            hold_off_cycles <= hold_off_cycles - 1;
        end
        else
            out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Sampled mid-cycle: what is seen here is what the next rising edge accepts.
    always @(negedge clk)
    begin
        sdf_result_t want;
        if (rst_n)
        begin
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("timeout: no beat accepted for %0d cycles", STALL_LIMIT);
                $display("glyph_signed_distance_sampler regression: fail");
                $finish;
            end
            if (out_ch.valid && out_ch.ready)
            begin
                result_count++;
                if (pending_results.size() == 0)
                    report_mismatch("unexpected result beat, distance_value",
                                    out_ch.distance_value, -1);
                else
                begin
                    want = pending_results.pop_front();
                    if (out_ch.distance_value !== want.distance_value)
                        report_mismatch("distance_value", out_ch.distance_value,
                                        want.distance_value);
                    if (out_ch.inside_res !== want.inside_res)
                        report_mismatch("inside_res", out_ch.inside_res, want.inside_res);
                end
            end
        end
    end

    initial
    begin
        cfg_write = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_ch.valid = 1'b0;
        in_ch.cmd = CMD_LOAD;
        in_ch.pixel_index = '0;
        in_ch.pixel_value = '0;
        in_ch.out_x = '0;
        in_ch.out_y = '0;
        out_ch.ready = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_off_cycles = 0;
        error_count = 0;
        load_count = 0;
        query_count = 0;
        result_count = 0;
        stall_cycles = 0;
        cfg_width = 64;
        cfg_height = 64;
        cfg_spread = 16;
        cfg_scale_x = 256;
        cfg_scale_y = 256;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_fill_and_defaults();
        test_config_extremes();
        test_backpressure();
        test_random_phase(0, 0, 10);
        test_random_phase(56, 0, 10);
        test_random_phase(0, 56, 10);
        test_random_phase(13, 13, 10);
        test_random_phase(0, 0, 5);

        drain_block();
        repeat (50) @(posedge clk);
        $display("Covered %0d pixel loads and %0d distance queries, %0d results checked,",
                 load_count, query_count, result_count);
        $display("across register extremes, receiver hold-off and four idling mixes.");
        if (error_count == 0 && pending_results.size() == 0)
            $display("glyph_signed_distance_sampler regression: pass");
        else
        begin
            $display("%0d mismatches, %0d results never arrived", error_count,
                     pending_results.size());
            $display("glyph_signed_distance_sampler regression: fail");
        end
        $finish;
    end

endmodule
